// ===== design/vsc_pkg.sv =====
// Package for the Vietnamese syllable checker: vowel table, letter codes, store depths.
// Used by vietnamese_syllable_checker and its checker module; no dependencies.
package vsc_pkg;

	localparam int IniDepth  = 3;
	localparam int VowDepth  = 5;
	localparam int TailDepth = 3;

	typedef logic [15:0] char_t;
	typedef logic [3:0]  base_t;
	typedef logic [2:0]  tone_t;
	typedef logic [2:0]  count_t;

	localparam base_t BaseA    = 4'd0;
	localparam base_t BaseE    = 4'd3;
	localparam base_t BaseEc   = 4'd4;
	localparam base_t BaseI    = 4'd5;
	localparam base_t BaseU    = 4'd9;
	localparam base_t BaseY    = 4'd11;

	localparam char_t ChB = 16'h0062;
	localparam char_t ChC = 16'h0063;
	localparam char_t ChD = 16'h0064;
	localparam char_t ChG = 16'h0067;
	localparam char_t ChH = 16'h0068;
	localparam char_t ChI = 16'h0069;
	localparam char_t ChK = 16'h006B;
	localparam char_t ChL = 16'h006C;
	localparam char_t ChM = 16'h006D;
	localparam char_t ChN = 16'h006E;
	localparam char_t ChP = 16'h0070;
	localparam char_t ChQ = 16'h0071;
	localparam char_t ChR = 16'h0072;
	localparam char_t ChS = 16'h0073;
	localparam char_t ChT = 16'h0074;
	localparam char_t ChU = 16'h0075;
	localparam char_t ChV = 16'h0076;
	localparam char_t ChX = 16'h0078;
	localparam char_t ChDd = 16'h0111;

	localparam tone_t ToneNone = 3'd0;
	localparam tone_t ToneSac  = 3'd1;
	localparam tone_t ToneNang = 3'd5;

	typedef char_t vowel_row_t [6];
	localparam vowel_row_t VowelForms [12] = '{
		'{16'h0061, 16'h00E1, 16'h00E0, 16'h1EA3, 16'h00E3, 16'h1EA1},
		'{16'h0103, 16'h1EAF, 16'h1EB1, 16'h1EB3, 16'h1EB5, 16'h1EB7},
		'{16'h00E2, 16'h1EA5, 16'h1EA7, 16'h1EA9, 16'h1EAB, 16'h1EAD},
		'{16'h0065, 16'h00E9, 16'h00E8, 16'h1EBB, 16'h1EBD, 16'h1EB9},
		'{16'h00EA, 16'h1EBF, 16'h1EC1, 16'h1EC3, 16'h1EC5, 16'h1EC7},
		'{16'h0069, 16'h00ED, 16'h00EC, 16'h1EC9, 16'h0129, 16'h1ECB},
		'{16'h006F, 16'h00F3, 16'h00F2, 16'h1ECF, 16'h00F5, 16'h1ECD},
		'{16'h00F4, 16'h1ED1, 16'h1ED3, 16'h1ED5, 16'h1ED7, 16'h1ED9},
		'{16'h01A1, 16'h1EDB, 16'h1EDD, 16'h1EDF, 16'h1EE1, 16'h1EE3},
		'{16'h0075, 16'h00FA, 16'h00F9, 16'h1EE7, 16'h0169, 16'h1EE5},
		'{16'h01B0, 16'h1EE9, 16'h1EEB, 16'h1EED, 16'h1EEF, 16'h1EF1},
		'{16'h0079, 16'h00FD, 16'h1EF3, 16'h1EF7, 16'h1EF9, 16'h1EF5}
	};

	localparam int NumClusters = 56;
	localparam logic [15:0] Clusters [NumClusters] = '{
		16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 16'h7, 16'h8, 16'h9, 16'hA, 16'hB, 16'hC,
		16'h16, 16'h17, 16'h1A, 16'h1C, 16'h3A, 16'h3C, 16'h47, 16'h5A, 16'h6A, 16'h71,
		16'h74, 16'h76, 16'h86, 16'h96, 16'hA1, 16'hA5, 16'hA6, 16'hAC, 16'hB1, 16'hB6,
		16'hBA, 16'h61, 16'h65, 16'hC5, 16'hC1, 16'hA8, 16'hB9, 16'h72, 16'h73, 16'hA3,
		16'hA9, 16'hAC5, 16'hAC1, 16'hACA, 16'hACA5,
		16'h65A, 16'h716, 16'h717, 16'h71C, 16'hA3C, 16'hA86, 16'hB96, 16'hB9A, 16'hC5A
	};

	// Case fold one code unit: ASCII capitals, D-stroke, uppercase vowel forms.
	function automatic char_t fold_char(input char_t c);
		char_t r;
		char_t up;
		r = c;
		if (c >= 16'h0041 && c <= 16'h005A) r = c + 16'h0020;
		if (c == 16'h0110) r = ChDd;
		for (int b = 0; b < 12; b++) begin
			for (int t = 0; t < 6; t++) begin
				if (VowelForms[b][t] >= 16'h00E0 && VowelForms[b][t] <= 16'h00FE)
					up = VowelForms[b][t] - 16'h0020;
				else if (VowelForms[b][t] >= 16'h0061 && VowelForms[b][t] <= 16'h007A)
					up = VowelForms[b][t] - 16'h0020;
				else
					up = VowelForms[b][t] - 16'h0001;
				if (up == c) r = VowelForms[b][t];
			end
		end
		return r;
	endfunction

endpackage

// ===== design/vietnamese_syllable_checker.sv =====
// Top level of the Vietnamese syllable checker: word buffers and spelling verdict.
// Depends on vsc_pkg for the vowel table, cluster table and letter codes.
//
// The block takes one UTF-16 code unit per transaction and, on the transaction that
// carries word_end, emits one verdict transaction (syllable_valid, tone_mark,
// has_vowel). While in_stall is low, a new transaction is accepted every cycle: stage 1
// registers the folded and classified character, stage 2 updates the word buffers and
// computes the verdict in the same pass, and a result register with a one-entry skid
// buffer holds the verdict so input keeps flowing while the output side stalls. Input
// stall is high while the skid entry is occupied, and also in the cycle in which a
// verdict leaves stage 1 while the result register is full and stalled, since that
// verdict takes the skid entry. Once the word_end transaction is accepted, stage 1
// registers it, then the result register or the skid entry takes its verdict.
// Words with no vowel, including empty words, are reported valid; any store overflow
// in a word with a vowel makes it invalid.
module vietnamese_syllable_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_point,
	input  logic        has_char,
	input  logic        word_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        syllable_valid,
	output logic [2:0]  tone_mark,
	output logic        has_vowel
);

	typedef struct packed {
		logic        valid;
		vsc_pkg::char_t ch;
		logic        has_char;
		logic        word_end;
		logic        is_vowel;
		vsc_pkg::base_t base;
		vsc_pkg::tone_t tone;
	} s1_t;

	typedef struct packed {
		logic           ok;
		vsc_pkg::tone_t tone;
		logic           vow;
	} verdict_t;

	s1_t s1_s1;
	s1_t s1_d;

	// Result register and skid entry.
	logic     res_valid_q, skid_valid_q;
	verdict_t res_q, skid_q;

	logic advance;
	logic emit;
	assign emit     = s1_s1.valid && s1_s1.word_end;
	assign in_stall = skid_valid_q || (res_valid_q && out_stall && emit);
	assign advance  = in_valid && !in_stall;

	// Stage 0: fold and classify.
	always_comb begin
		s1_d          = '0;
		s1_d.valid    = advance;
		s1_d.ch       = vsc_pkg::fold_char(code_point);
		s1_d.has_char = has_char;
		s1_d.word_end = word_end;
		for (int b = 0; b < 12; b++) begin
			for (int t = 0; t < 6; t++) begin
				if (vsc_pkg::VowelForms[b][t] == s1_d.ch) begin
					s1_d.is_vowel = 1'b1;
					s1_d.base     = vsc_pkg::base_t'(b);
					s1_d.tone     = vsc_pkg::tone_t'(t);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_s1 <= '0;
		end else begin
			s1_s1 <= s1_d;
		end
	end

	// Word state.
	vsc_pkg::char_t ini_q [vsc_pkg::IniDepth];
	vsc_pkg::base_t vow_q [vsc_pkg::VowDepth];
	vsc_pkg::char_t tail_q [vsc_pkg::TailDepth];
	vsc_pkg::count_t ini_cnt_q, vow_cnt_q, tail_cnt_q;
	vsc_pkg::tone_t tone_q;
	logic seen_q, ini_over_q, vow_over_q, tail_over_q;

	// State after the current character is added (next-state view).
	vsc_pkg::char_t ini_n [vsc_pkg::IniDepth];
	vsc_pkg::base_t vow_n [vsc_pkg::VowDepth];
	vsc_pkg::char_t tail_n [vsc_pkg::TailDepth];
	vsc_pkg::count_t ini_cnt_n, vow_cnt_n, tail_cnt_n;
	vsc_pkg::tone_t tone_n;
	logic seen_n, ini_over_n, vow_over_n, tail_over_n;

	always_comb begin
		ini_n = ini_q; vow_n = vow_q; tail_n = tail_q;
		ini_cnt_n = ini_cnt_q; vow_cnt_n = vow_cnt_q; tail_cnt_n = tail_cnt_q;
		tone_n = tone_q; seen_n = seen_q;
		ini_over_n = ini_over_q; vow_over_n = vow_over_q; tail_over_n = tail_over_q;
		if (s1_s1.valid && s1_s1.has_char) begin
			if (s1_s1.is_vowel) begin
				seen_n = 1'b1;
				if (vow_cnt_q < 3'(vsc_pkg::VowDepth)) begin
					vow_n[vow_cnt_q] = s1_s1.base;
					vow_cnt_n = vow_cnt_q + 3'd1;
				end else begin
					vow_over_n = 1'b1;
				end
				if (s1_s1.tone != vsc_pkg::ToneNone) tone_n = s1_s1.tone;
				tail_cnt_n  = '0;
				tail_over_n = 1'b0;
			end else if (!seen_q) begin
				if (ini_cnt_q < 3'(vsc_pkg::IniDepth)) begin
					ini_n[ini_cnt_q[1:0]] = s1_s1.ch;
					ini_cnt_n = ini_cnt_q + 3'd1;
				end else begin
					ini_over_n = 1'b1;
				end
			end else begin
				if (tail_cnt_q < 3'(vsc_pkg::TailDepth)) begin
					tail_n[tail_cnt_q[1:0]] = s1_s1.ch;
					tail_cnt_n = tail_cnt_q + 3'd1;
				end else begin
					tail_over_n = 1'b1;
				end
			end
		end
	end

	// Verdict on the next-state view.
	verdict_t verdict;
	logic qu_split, ini_ok, clu_ok, fin_ok;
	logic i_k, i_gh, i_ngh, i_c, i_ng, i_g;
	logic f_stop;
	logic [19:0] code;
	vsc_pkg::base_t v0;
	vsc_pkg::char_t a0, a1, a2;
	vsc_pkg::count_t ni;

	always_comb begin
		qu_split = (ini_cnt_n == 3'd1) && (ini_n[0] == vsc_pkg::ChQ)
			&& (vow_n[0] == vsc_pkg::BaseU) && (vow_cnt_n > 3'd1);
		a0 = ini_n[0];
		a1 = qu_split ? vsc_pkg::ChU : ini_n[1];
		a2 = ini_n[2];
		ni = qu_split ? 3'd2 : ini_cnt_n;

		i_k   = (ni == 3'd1) && a0 == vsc_pkg::ChK;
		i_c   = (ni == 3'd1) && a0 == vsc_pkg::ChC;
		i_g   = (ni == 3'd1) && a0 == vsc_pkg::ChG;
		i_gh  = (ni == 3'd2) && a0 == vsc_pkg::ChG && a1 == vsc_pkg::ChH;
		i_ng  = (ni == 3'd2) && a0 == vsc_pkg::ChN && a1 == vsc_pkg::ChG;
		i_ngh = (ni == 3'd3) && a0 == vsc_pkg::ChN && a1 == vsc_pkg::ChG
			&& a2 == vsc_pkg::ChH;

		ini_ok = 1'b0;
		case (ni)
			3'd0: ini_ok = 1'b1;
			3'd1: ini_ok = a0 == vsc_pkg::ChB || a0 == vsc_pkg::ChC || a0 == vsc_pkg::ChD
				|| a0 == vsc_pkg::ChG || a0 == vsc_pkg::ChH || a0 == vsc_pkg::ChK
				|| a0 == vsc_pkg::ChL || a0 == vsc_pkg::ChM || a0 == vsc_pkg::ChN
				|| a0 == vsc_pkg::ChP || a0 == vsc_pkg::ChR || a0 == vsc_pkg::ChS
				|| a0 == vsc_pkg::ChT || a0 == vsc_pkg::ChV || a0 == vsc_pkg::ChX
				|| a0 == vsc_pkg::ChDd;
			3'd2: ini_ok =
				(a0 == vsc_pkg::ChC && a1 == vsc_pkg::ChH)
				|| (a0 == vsc_pkg::ChG && a1 == vsc_pkg::ChH)
				|| (a0 == vsc_pkg::ChG && a1 == vsc_pkg::ChI)
				|| (a0 == vsc_pkg::ChK && a1 == vsc_pkg::ChH)
				|| (a0 == vsc_pkg::ChN && a1 == vsc_pkg::ChG)
				|| (a0 == vsc_pkg::ChN && a1 == vsc_pkg::ChH)
				|| (a0 == vsc_pkg::ChP && a1 == vsc_pkg::ChH)
				|| (a0 == vsc_pkg::ChQ && a1 == vsc_pkg::ChU)
				|| (a0 == vsc_pkg::ChT && a1 == vsc_pkg::ChH)
				|| (a0 == vsc_pkg::ChT && a1 == vsc_pkg::ChR);
			3'd3: ini_ok = i_ngh;
			default: ini_ok = 1'b0;
		endcase

		// Cluster code: one nibble per vowel, base plus one, skipping the u of qu.
		// Five vowels outside a qu split give five nibbles, which no table entry matches.
		code = '0;
		for (int i = 0; i < vsc_pkg::VowDepth; i++) begin
			if (3'(i) < vow_cnt_n && !(qu_split && i == 0))
				code = {code[15:0], vow_n[i] + 4'd1};
		end
		clu_ok = 1'b0;
		for (int i = 0; i < vsc_pkg::NumClusters; i++) begin
			if ({4'h0, vsc_pkg::Clusters[i]} == code) clu_ok = 1'b1;
		end
		// A sixth vowel sets the overflow flag, which fails such words below.

		fin_ok = 1'b0;
		f_stop = 1'b0;
		case (tail_cnt_n)
			3'd0: fin_ok = 1'b1;
			3'd1: begin
				fin_ok = tail_n[0] == vsc_pkg::ChC || tail_n[0] == vsc_pkg::ChM
					|| tail_n[0] == vsc_pkg::ChN || tail_n[0] == vsc_pkg::ChP
					|| tail_n[0] == vsc_pkg::ChT;
				f_stop = tail_n[0] == vsc_pkg::ChC || tail_n[0] == vsc_pkg::ChP
					|| tail_n[0] == vsc_pkg::ChT;
			end
			3'd2: begin
				fin_ok = (tail_n[0] == vsc_pkg::ChC && tail_n[1] == vsc_pkg::ChH)
					|| (tail_n[0] == vsc_pkg::ChN && tail_n[1] == vsc_pkg::ChG)
					|| (tail_n[0] == vsc_pkg::ChN && tail_n[1] == vsc_pkg::ChH);
				f_stop = tail_n[0] == vsc_pkg::ChC && tail_n[1] == vsc_pkg::ChH;
			end
			default: fin_ok = 1'b0;
		endcase

		v0 = qu_split ? vow_n[1] : vow_n[0];

		verdict.tone = tone_n;
		verdict.vow  = seen_n;
		if (!seen_n) begin
			verdict.ok = 1'b1;
		end else if (ini_over_n || vow_over_n || tail_over_n) begin
			verdict.ok = 1'b0;
		end else begin
			verdict.ok = ini_ok && clu_ok && fin_ok;
			if (f_stop && tone_n != vsc_pkg::ToneNone && tone_n != vsc_pkg::ToneSac
				&& tone_n != vsc_pkg::ToneNang) verdict.ok = 1'b0;
			if ((i_k || i_gh || i_ngh) && v0 != vsc_pkg::BaseE && v0 != vsc_pkg::BaseEc
				&& v0 != vsc_pkg::BaseI && v0 != vsc_pkg::BaseY) verdict.ok = 1'b0;
			if ((i_c || i_ng) && (v0 == vsc_pkg::BaseE || v0 == vsc_pkg::BaseEc
				|| v0 == vsc_pkg::BaseI)) verdict.ok = 1'b0;
			if (i_g && (v0 == vsc_pkg::BaseE || v0 == vsc_pkg::BaseEc)) verdict.ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ini_cnt_q <= '0; vow_cnt_q <= '0; tail_cnt_q <= '0;
			tone_q <= '0; seen_q <= 1'b0;
			ini_over_q <= 1'b0; vow_over_q <= 1'b0; tail_over_q <= 1'b0;
		end else if (emit) begin
			ini_cnt_q <= '0; vow_cnt_q <= '0; tail_cnt_q <= '0;
			tone_q <= '0; seen_q <= 1'b0;
			ini_over_q <= 1'b0; vow_over_q <= 1'b0; tail_over_q <= 1'b0;
		end else begin
			ini_cnt_q <= ini_cnt_n; vow_cnt_q <= vow_cnt_n; tail_cnt_q <= tail_cnt_n;
			tone_q <= tone_n; seen_q <= seen_n;
			ini_over_q <= ini_over_n; vow_over_q <= vow_over_n; tail_over_q <= tail_over_n;
		end
	end

	always_ff @(posedge clk) begin
		ini_q  <= ini_n;
		vow_q  <= vow_n;
		tail_q <= tail_n;
	end

	// Output register with skid entry. Stage 1 holds at most one item, and the
	// skid fills when a verdict arrives while the result register is stalled or the skid is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || !out_stall) begin
				if (skid_valid_q) begin
					res_valid_q  <= 1'b1;
					res_q        <= skid_q;
					skid_valid_q <= 1'b0;
					if (emit) begin
						skid_valid_q <= 1'b1;
						skid_q       <= verdict;
					end
				end else begin
					res_valid_q <= emit;
					if (emit) res_q <= verdict;
				end
			end else if (emit) begin
				skid_valid_q <= 1'b1;
				skid_q       <= verdict;
			end
		end
	end

	assign out_valid      = res_valid_q;
	assign syllable_valid = res_q.ok;
	assign tone_mark      = res_q.tone;
	assign has_vowel      = res_q.vow;

endmodule

// ===== design/vsc_checker.sv =====
// Port-level checker for vietnamese_syllable_checker, attached by bind.
// Depends on vsc_pkg for tone codes.
module vsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       syllable_valid,
	input logic [2:0] tone_mark,
	input logic       has_vowel
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tone_mark)
		&& $stable(syllable_valid) && $stable(has_vowel))
		else $error("stalled result changed");

	a_tone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tone_mark <= vsc_pkg::ToneNang)
		else $error("tone out of range");

	a_novowel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_vowel |-> syllable_valid && tone_mark == vsc_pkg::ToneNone)
		else $error("word without vowel must be valid with no tone");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && (out_stall || $past(out_stall)))
		else $error("input stalled without a held result");

endmodule

bind vietnamese_syllable_checker vsc_checker u_vsc_checker (.*);

// ===== verif/vietnamese_syllable_checker_tb.sv =====
// Testbench for vietnamese_syllable_checker: drives words one code unit per transaction
// and checks each verdict against an in-bench spelling predictor. Depends on vsc_pkg.
`timescale 1ns / 1ps

module vietnamese_syllable_checker_tb;

	typedef struct packed {
		logic [15:0] code_point;
		logic        has_char;
		logic        word_end;
	} char_item_t;

	typedef struct packed {
		logic       syllable_valid;
		logic [2:0] tone_mark;
		logic       has_vowel;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_point;
	logic        has_char;
	logic        word_end;
	logic        out_valid;
	logic        out_stall;
	logic        syllable_valid;
	logic [2:0]  tone_mark;
	logic        has_vowel;

	vietnamese_syllable_checker i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.code_point(code_point), .has_char(has_char), .word_end(word_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.syllable_valid(syllable_valid), .tone_mark(tone_mark), .has_vowel(has_vowel)
	);

	// Lower-case vowel letters, rows are bases and columns are tones.
	localparam logic [15:0] LetterTable [12][6] = '{
		'{16'h0061, 16'h00E1, 16'h00E0, 16'h1EA3, 16'h00E3, 16'h1EA1},
		'{16'h0103, 16'h1EAF, 16'h1EB1, 16'h1EB3, 16'h1EB5, 16'h1EB7},
		'{16'h00E2, 16'h1EA5, 16'h1EA7, 16'h1EA9, 16'h1EAB, 16'h1EAD},
		'{16'h0065, 16'h00E9, 16'h00E8, 16'h1EBB, 16'h1EBD, 16'h1EB9},
		'{16'h00EA, 16'h1EBF, 16'h1EC1, 16'h1EC3, 16'h1EC5, 16'h1EC7},
		'{16'h0069, 16'h00ED, 16'h00EC, 16'h1EC9, 16'h0129, 16'h1ECB},
		'{16'h006F, 16'h00F3, 16'h00F2, 16'h1ECF, 16'h00F5, 16'h1ECD},
		'{16'h00F4, 16'h1ED1, 16'h1ED3, 16'h1ED5, 16'h1ED7, 16'h1ED9},
		'{16'h01A1, 16'h1EDB, 16'h1EDD, 16'h1EDF, 16'h1EE1, 16'h1EE3},
		'{16'h0075, 16'h00FA, 16'h00F9, 16'h1EE7, 16'h0169, 16'h1EE5},
		'{16'h01B0, 16'h1EE9, 16'h1EEB, 16'h1EED, 16'h1EEF, 16'h1EF1},
		'{16'h0079, 16'h00FD, 16'h1EF3, 16'h1EF7, 16'h1EF9, 16'h1EF5}
	};

	// Allowed vowel clusters, one nibble per vowel holding base plus one.
	localparam int ClusterCount = 56;
	localparam logic [19:0] ClusterTable [ClusterCount] = '{
		20'h1, 20'h2, 20'h3, 20'h4, 20'h5, 20'h6, 20'h7, 20'h8, 20'h9, 20'hA, 20'hB, 20'hC,
		20'h16, 20'h17, 20'h1A, 20'h1C, 20'h3A, 20'h3C, 20'h47, 20'h5A, 20'h6A, 20'h71,
		20'h74, 20'h76, 20'h86, 20'h96, 20'hA1, 20'hA5, 20'hA6, 20'hAC, 20'hB1, 20'hB6,
		20'hBA, 20'h61, 20'h65, 20'hC5, 20'hC1, 20'hA8, 20'hB9, 20'h72, 20'h73, 20'hA3,
		20'hA9, 20'hAC5, 20'hAC1, 20'hACA, 20'hACA5,
		20'h65A, 20'h716, 20'h717, 20'h71C, 20'hA3C, 20'hA86, 20'hB96, 20'hB9A, 20'hC5A
	};

	// Consonant strings are packed as up to three 16-bit units plus a length.
	typedef struct packed {
		logic [1:0]  len;
		logic [47:0] units;
	} cons_str_t;

	function automatic cons_str_t mk(input string s);
		cons_str_t r;
		r = '0;
		r.len = 2'(s.len());
		for (int i = 0; i < s.len(); i++) r.units[16*i +: 16] = {8'h00, s[i]};
		return r;
	endfunction

	localparam int OnsetCount = 26;
	string onset_names [OnsetCount] = '{"b", "c", "ch", "d", "g", "gh", "gi", "h", "k",
		"kh", "l", "m", "n", "ng", "ngh", "nh", "p", "ph", "qu", "r", "s", "t", "th", "tr",
		"v", "x"};
	localparam int CodaCount = 9;
	string coda_names [CodaCount] = '{"", "c", "ch", "m", "n", "ng", "nh", "p", "t"};

	// Predictor state for the word in progress.
	logic [15:0] onset_buf [3];
	int          onset_len;
	logic [3:0]  nucleus_buf [5];
	int          nucleus_len;
	logic [15:0] coda_buf [3];
	int          coda_len;
	logic [2:0]  last_tone;
	bit          word_has_vowel;
	bit          onset_over, nucleus_over, coda_over;

	char_item_t  pending_chars [$];
	verdict_t    expected_verdicts [$];
	int          error_count;
	int          hold_off_cycles;
	bit          stimulus_done;

	// Lower-case fold that follows the block's rules: ASCII capitals, D-stroke
	// and the capital form of every vowel letter.
	function automatic logic [15:0] lower_of(input logic [15:0] c);
		logic [15:0] cap;
		if (c >= 16'h0041 && c <= 16'h005A) return c + 16'h0020;
		if (c == 16'h0110) return vsc_pkg::ChDd;
		for (int b = 0; b < 12; b++)
			for (int t = 0; t < 6; t++) begin
				if ((LetterTable[b][t] >= 16'h0061 && LetterTable[b][t] <= 16'h007A) ||
				    (LetterTable[b][t] >= 16'h00E0 && LetterTable[b][t] <= 16'h00FE))
					cap = LetterTable[b][t] - 16'h0020;
				else
					cap = LetterTable[b][t] - 16'h0001;
				if (cap == c) return LetterTable[b][t];
			end
		return c;
	endfunction

	function automatic cons_str_t pack_buf(input logic [15:0] b [3], input int n);
		cons_str_t r;
		r = '0;
		r.len = 2'(n);
		for (int i = 0; i < n; i++) r.units[16*i +: 16] = b[i];
		return r;
	endfunction

	function automatic bit spelling_ok();
		cons_str_t on, co;
		int          first;
		logic [19:0] code;
		bit          ok;
		logic [3:0]  v0;
		if (!word_has_vowel) return 1;
		if (onset_over || nucleus_over || coda_over) return 0;
		// A lone q followed by u and another vowel is the initial qu.
		if (onset_len == 1 && onset_buf[0] == vsc_pkg::ChQ &&
		    nucleus_buf[0] == vsc_pkg::BaseU && nucleus_len > 1) begin
			on = mk("qu");
			first = 1;
		end else begin
			on = pack_buf(onset_buf, onset_len);
			first = 0;
		end
		if (on.len != 0) begin
			ok = (on.len == 1 && on.units[15:0] == vsc_pkg::ChDd);
			foreach (onset_names[i]) if (on == mk(onset_names[i])) ok = 1;
			if (!ok) return 0;
		end
		code = '0;
		for (int i = first; i < nucleus_len; i++)
			code = {code[15:0], nucleus_buf[i] + 4'd1};
		ok = 0;
		foreach (ClusterTable[i]) if (ClusterTable[i] == code) ok = 1;
		if (!ok) return 0;
		co = pack_buf(coda_buf, coda_len);
		ok = 0;
		foreach (coda_names[i]) if (co == mk(coda_names[i])) ok = 1;
		if (!ok) return 0;
		// Stop finals take only the level, sharp or heavy tone.
		if (co == mk("c") || co == mk("ch") || co == mk("p") || co == mk("t"))
			if (last_tone != vsc_pkg::ToneNone && last_tone != vsc_pkg::ToneSac &&
			    last_tone != vsc_pkg::ToneNang)
				return 0;
		v0 = nucleus_buf[first];
		if (on == mk("k") || on == mk("gh") || on == mk("ngh"))
			if (v0 != vsc_pkg::BaseE && v0 != vsc_pkg::BaseEc && v0 != vsc_pkg::BaseI &&
			    v0 != vsc_pkg::BaseY) return 0;
		if (on == mk("c") || on == mk("ng"))
			if (v0 == vsc_pkg::BaseE || v0 == vsc_pkg::BaseEc || v0 == vsc_pkg::BaseI)
				return 0;
		if (on == mk("g"))
			if (v0 == vsc_pkg::BaseE || v0 == vsc_pkg::BaseEc) return 0;
		return 1;
	endfunction

	task automatic clear_word_state();
		onset_len = 0; nucleus_len = 0; coda_len = 0;
		last_tone = vsc_pkg::ToneNone; word_has_vowel = 0;
		onset_over = 0; nucleus_over = 0; coda_over = 0;
	endtask

	// Advances the predictor by one accepted transaction.
	task automatic predict_char(input char_item_t it);
		logic [15:0] lc;
		bit          is_vowel;
		int          vb, vt;
		verdict_t    v;
		lc = lower_of(it.code_point);
		is_vowel = 0;
		vb = 0; vt = 0;
		for (int b = 0; b < 12; b++)
			for (int t = 0; t < 6; t++)
				if (!is_vowel && LetterTable[b][t] == lc) begin
					is_vowel = 1; vb = b; vt = t;
				end
		if (it.has_char) begin
			if (is_vowel) begin
				word_has_vowel = 1;
				if (nucleus_len < vsc_pkg::VowDepth) nucleus_buf[nucleus_len++] = 4'(vb);
				else nucleus_over = 1;
				if (vt != 0) last_tone = 3'(vt);
				// Consonants between vowels are dropped.
				coda_len = 0;
				coda_over = 0;
			end else if (!word_has_vowel) begin
				if (onset_len < vsc_pkg::IniDepth) onset_buf[onset_len++] = lc;
				else onset_over = 1;
			end else begin
				if (coda_len < vsc_pkg::TailDepth) coda_buf[coda_len++] = lc;
				else coda_over = 1;
			end
		end
		if (it.word_end) begin
			v.syllable_valid = spelling_ok();
			v.tone_mark = last_tone;
			v.has_vowel = word_has_vowel;
			expected_verdicts.push_back(v);
			clear_word_state();
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Word generation helpers.
	task automatic push_char(input logic [15:0] c, input bit last);
		char_item_t it;
		it.code_point = c;
		it.has_char = 1;
		it.word_end = last;
		pending_chars.push_back(it);
	endtask

	task automatic push_word(input string s);
		for (int i = 0; i < s.len(); i++) push_char({8'h00, s[i]}, i == s.len() - 1);
	endtask

	function automatic logic [15:0] any_vowel();
		logic [15:0] c;
		c = LetterTable[$urandom_range(11)][$urandom_range(5)];
		// Capital forms exercise the fold.
		if ($urandom_range(3) == 0) begin
			if ((c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h00E0 && c <= 16'h00FE))
				c = c - 16'h0020;
			else
				c = c - 16'h0001;
		end
		return c;
	endfunction

	function automatic logic [15:0] maybe_upper(input logic [15:0] c);
		if (c >= 16'h0061 && c <= 16'h007A && $urandom_range(3) == 0) return c - 16'h0020;
		if (c == vsc_pkg::ChDd && $urandom_range(1)) return 16'h0110;
		return c;
	endfunction

	// A mostly well-formed syllable with random content.
	task automatic push_random_word();
		string       on, co;
		int          nv, cl;
		logic [19:0] code;
		logic [15:0] chars [$];
		if ($urandom_range(9) == 0) on = "";
		else if ($urandom_range(19) == 0) on = "q";
		else on = onset_names[$urandom_range(OnsetCount - 1)];
		if (on == "d" && $urandom_range(3) == 0) chars.push_back(vsc_pkg::ChDd);
		else for (int i = 0; i < on.len(); i++) chars.push_back({8'h00, on[i]});
		if (on == "q") chars.push_back(vsc_pkg::ChU);
		cl = $urandom_range(ClusterCount - 1);
		code = ClusterTable[cl];
		nv = 0;
		for (int i = 4; i >= 0; i--) if (code[4*i +: 4] != 0 && nv == 0) nv = i + 1;
		for (int i = nv - 1; i >= 0; i--)
			chars.push_back(LetterTable[code[4*i +: 4] - 1][$urandom_range(5)]);
		co = coda_names[$urandom_range(CodaCount - 1)];
		for (int i = 0; i < co.len(); i++) chars.push_back({8'h00, co[i]});
		// Occasional damage: random unit inserted.
		if ($urandom_range(4) == 0)
			chars.insert($urandom_range(chars.size()), $urandom_range(1) ?
				any_vowel() : 16'($urandom()));
		foreach (chars[i]) push_char(maybe_upper(chars[i]), i == chars.size() - 1);
	endtask

	task automatic push_noise_word();
		int n;
		n = $urandom_range(8);
		for (int i = 0; i < n; i++) begin
			char_item_t it;
			it.code_point = 16'($urandom());
			it.has_char = $urandom_range(3) != 0;
			it.word_end = 1'b0;
			if ($urandom_range(2) == 0) it.code_point = any_vowel();
			pending_chars.push_back(it);
		end
		begin
			char_item_t it;
			it.code_point = 16'($urandom());
			it.has_char = 1'($urandom_range(1));
			it.word_end = 1'b1;
			pending_chars.push_back(it);
		end
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// Directed words, then random words until about 1950 transactions are queued.
	initial begin
		char_item_t it;
		clear_word_state();
		error_count = 0;
		stimulus_done = 0;
		it = '{code_point: 16'hFFFF, has_char: 0, word_end: 1};
		pending_chars.push_back(it);   // empty word
		it = '{code_point: 16'h0000, has_char: 0, word_end: 0};
		pending_chars.push_back(it);   // idle transaction
		push_word("bcdfgh");           // no vowel at all
		push_word("ngheng");
		push_word("qua");
		push_word("qu");
		push_word("ke");
		push_word("ka");
		push_word("ce");
		push_word("ge");
		push_word("tuyen");
		push_word("nghiengg");         // final ngg, not a valid final
		push_word("aaaaaa");           // vowel overflow
		push_word("nghha");            // initial overflow
		push_word("uyuya");            // five vowels, no cluster of that length
		push_char(16'h0110, 0); push_char(16'h00C1, 0); push_char(vsc_pkg::ChT, 1);
		push_char(vsc_pkg::ChC, 0); push_char(16'h00E0, 0);
		push_char(vsc_pkg::ChP, 1);                                   // stop final, bad tone
		push_char(vsc_pkg::ChM, 0); push_char(16'h1EA1, 0); push_char(vsc_pkg::ChC, 1);
		push_char(vsc_pkg::ChB, 0); push_char(16'h0041, 0); push_char(vsc_pkg::ChT, 0);
		push_char(16'h01B0, 0); push_char(vsc_pkg::ChN, 1);           // dropped middle consonant
		push_char(16'hFFFF, 0); push_char(16'h0000, 1);
		while (pending_chars.size() < 1950) begin
			if ($urandom_range(7) == 0) push_noise_word();
			else push_random_word();
		end
		stimulus_done = 1;
	end

	// Input handshake as seen at the rising edge; the predictor advances here.
	logic in_stall_q;
	int   accepted_count;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_stall_q <= 1'b0;
			accepted_count <= 0;
		end else begin
			in_stall_q <= in_stall;
			if (in_valid && !in_stall) begin
				predict_char('{code_point: code_point, has_char: has_char, word_end: word_end});
				accepted_count <= accepted_count + 1;
			end
		end
	end

	// Driver: feeds the queue of pending transactions with random gaps.
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			code_point <= '0;
			has_char <= 1'b0;
			word_end <= 1'b0;
			gap_left <= 0;
		end else begin
			// Retire the transaction taken at the last rising edge.
			bit taken;
			taken = in_valid && !in_stall_q;
			if (in_valid && !taken) begin
				// Hold the stalled payload.
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_chars.size() > 0) begin
				char_item_t it;
				it = pending_chars.pop_front();
				in_valid <= 1'b1;
				code_point <= it.code_point;
				has_char <= it.has_char;
				word_end <= it.word_end;
				gap_left <= ($urandom_range(19) == 0) ? $urandom_range(30) :
				            ($urandom_range(2) == 0 ? $urandom_range(2) : 0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: random, plus one long hold-off once traffic is underway.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			hold_off_cycles <= 0;
		end else if (accepted_count > 400 && accepted_count < 410 && hold_off_cycles == 0) begin
			hold_off_cycles <= 80;
			out_stall <= 1'b1;
		end else if (hold_off_cycles > 1) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			if (hold_off_cycles == 1) hold_off_cycles <= -1;
			out_stall <= ($urandom_range(9) == 0) ? 1'b1 :
			             ($urandom_range(2) == 0 && $urandom_range(1) == 0);
		end
	end

	// Monitor: each verdict transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("verdict with none expected");
			end else begin
				verdict_t v;
				v = expected_verdicts.pop_front();
				if (syllable_valid !== v.syllable_valid)
					report_mismatch($sformatf("syllable_valid %b want %b",
						syllable_valid, v.syllable_valid));
				if (tone_mark !== v.tone_mark)
					report_mismatch($sformatf("tone_mark %0d want %0d", tone_mark, v.tone_mark));
				if (has_vowel !== v.has_vowel)
					report_mismatch($sformatf("has_vowel %b want %b", has_vowel, v.has_vowel));
			end
		end
	end

	// End of run: all transactions taken, all verdicts seen, then a short drain.
	initial begin
		wait (stimulus_done);
		wait (pending_chars.size() == 0 && !in_valid);
		wait (expected_verdicts.size() == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_verdicts.size() == 0)
			$display("vietnamese_syllable_checker_tb: done, clean");
		else
			$display("vietnamese_syllable_checker_tb: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("vietnamese_syllable_checker_tb: done, errors");
		$finish;
	end

endmodule
